// ----- rtl/core/jts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package jts_pkg;

    localparam int unsigned TimeWidth   = 63;
    localparam int unsigned PeriodWidth = 32;
    localparam int unsigned Q16Width    = 17;
    localparam int unsigned ThrWidth    = PeriodWidth + Q16Width;
    localparam int unsigned CfgIdxWidth = 4;
    localparam int unsigned CfgDataWidth = 32;

    localparam logic [Q16Width-1:0]  Q16One   = 17'h10000;
    localparam logic [TimeWidth-1:0] TimeMax  = {TimeWidth{1'b1}};

    // Register reset values: 0.95 and 0.50 in Q16
    localparam logic [Q16Width-1:0] SmoothWeightReset = 17'd62259;
    localparam logic [Q16Width-1:0] JitterLimitReset  = 17'd32768;

    localparam logic [CfgIdxWidth-1:0] CFG_SMOOTH_WEIGHT = 4'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_JITTER_LIMIT  = 4'd1;

    typedef struct packed {
        logic [TimeWidth-1:0]   arrival_time;
        logic [PeriodWidth-1:0] period;
    } in_item_t;

    typedef struct packed {
        logic [TimeWidth-1:0] filtered_time;
        logic                 resynced;
    } out_item_t;

    // Registered item plus its acceptance threshold period * jitter_limit
    typedef struct packed {
        logic [TimeWidth-1:0]   arrival_time;
        logic [PeriodWidth-1:0] period;
        logic [ThrWidth-1:0]    thr;
    } work_t;

endpackage

`default_nettype wire

// ----- rtl/core/jts_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jts_in_stage
    import jts_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_item_t            s_data,
    input  wire logic [Q16Width-1:0] jitter_limit,
    input  wire logic                advance,
    output logic                     work_valid,
    output work_t                    work
);

    logic  valid_reg;
    logic  valid_next;
    work_t work_reg;
    logic  load;

    // Take a new item when empty or when the held one moves on
    assign s_ready    = !valid_reg || advance;
    assign load       = s_valid && s_ready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            work_reg.arrival_time <= s_data.arrival_time;
            work_reg.period       <= s_data.period;
            work_reg.thr          <= {{Q16Width{1'b0}}, s_data.period}
                                   * {{PeriodWidth{1'b0}}, jitter_limit};
        end
    end

    assign work_valid = valid_reg;
    assign work       = work_reg;

endmodule

`default_nettype wire

// ----- rtl/core/jts_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jts_filter
    import jts_pkg::*;
(
    input  wire work_t               work,
    input  wire logic [TimeWidth-1:0] last_time,
    input  wire logic [Q16Width-1:0] smooth_weight,
    output out_item_t                result
);

    logic [TimeWidth:0]         pred;
    logic                       neg;
    logic [TimeWidth:0]         mag;
    logic                       small_err;
    logic [Q16Width-1:0]        w_sat;
    logic [Q16Width-1:0]        frac;
    logic [49:0]                prod;
    logic signed [51:0]         sprod;
    logic signed [35:0]         corr;
    logic signed [65:0]         sum;
    logic                       use_corr;
    logic [TimeWidth-1:0]       corrected;

    always_comb begin
        pred = {1'b0, last_time} + {{(TimeWidth+1-PeriodWidth){1'b0}}, work.period};
        neg  = {1'b0, work.arrival_time} < pred;
        mag  = neg ? pred - {1'b0, work.arrival_time} : {1'b0, work.arrival_time} - pred;

        small_err = (mag[TimeWidth:33] == '0) && ({mag[32:0], 16'd0} < work.thr);

        w_sat = (smooth_weight > Q16One) ? Q16One : smooth_weight;
        frac  = Q16One - w_sat;
        prod  = {{Q16Width{1'b0}}, mag[32:0]} * {33'd0, frac};

        // Signed error times (1 - weight), round half up to Q0
        sprod = neg ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
        sprod = sprod + 52'sd32768;
        corr  = 36'(sprod >>> 16);

        sum = $signed({2'b00, pred}) + 66'(corr);
        if (sum[65]) begin
            corrected = '0;
        end else if (sum[64:63] != 2'b00) begin
            corrected = TimeMax;
        end else begin
            corrected = sum[62:0];
        end

        use_corr = (last_time != '0) && (smooth_weight != '0) && small_err;

        result.filtered_time = use_corr ? corrected : work.arrival_time;
        result.resynced      = !use_corr;
    end

endmodule

`default_nettype wire

// ----- rtl/core/jts_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jts_out_stage
    import jts_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            work_valid,
    input  wire out_item_t       result,
    output logic                 advance,
    output logic [TimeWidth-1:0] last_time,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output out_item_t            m_data
);

    logic                 valid_reg;
    logic                 valid_next;
    out_item_t            data_reg;
    logic [TimeWidth-1:0] last_reg;

    assign advance    = work_valid && (!valid_reg || m_ready);
    assign valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            last_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            if (advance) begin
                last_reg <= result.filtered_time;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= result;
        end
    end

    assign m_valid   = valid_reg;
    assign m_data    = data_reg;
    assign last_time = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/timestamp_jitter_smoother_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    in_item_t  (arrival_time, period)
// m_        out        m_valid / m_ready    out_item_t (filtered_time, resynced)
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while m_ready is high; an accepted item passes
// the input register and then the result register, where it raises m_valid.
// The loop through last filtered time closes in the single filter datapath
// between the input register and the result register.
// Reset (aresetn low, synchronous) empties both registers, clears the history
// and loads the default weight 0.95 and jitter limit 0.50.
// A stalled result holds in the output register while one more item is taken in.

module timestamp_jitter_smoother_core
    import jts_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire in_item_t                s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output out_item_t                    m_data,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CfgIdxWidth-1:0]  cfg_index,
    input  wire logic [CfgDataWidth-1:0] cfg_data
);

    logic [Q16Width-1:0]  smooth_weight_reg;
    logic [Q16Width-1:0]  jitter_limit_reg;
    logic                 advance;
    logic                 work_valid;
    work_t                work;
    out_item_t            result;
    logic [TimeWidth-1:0] last_time;

    // Configuration transfers are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_weight_reg <= SmoothWeightReset;
            jitter_limit_reg  <= JitterLimitReset;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SMOOTH_WEIGHT: smooth_weight_reg <= cfg_data[Q16Width-1:0];
                CFG_JITTER_LIMIT:  jitter_limit_reg  <= cfg_data[Q16Width-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the item and its precomputed jitter threshold
    jts_in_stage u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .jitter_limit (jitter_limit_reg),
        .advance      (advance),
        .work_valid   (work_valid),
        .work         (work)
    );

    // Predict, check the error, correct or resync
    jts_filter u_filter (
        .work          (work),
        .last_time     (last_time),
        .smooth_weight (smooth_weight_reg),
        .result        (result)
    );

    // Result register and filter history advance together
    jts_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .work_valid (work_valid),
        .result     (result),
        .advance    (advance),
        .last_time  (last_time),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // History always matches the result on show
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (last_time == m_data.filtered_time))
        else $error("history differs from result register");

    // An item moving on is always shown next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced item not shown");

    // A held item is not lost while the output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        (work_valid && !advance) |=> work_valid)
        else $error("held item dropped");

endmodule

`default_nettype wire
